// File: hw/rtl/rau_pkg.sv
`timescale 1ns / 1ps
// Package for the rational arithmetic unit.
// Holds operation and error codes shared by the sequencer and the port packing.
// No dependencies.
package rau_pkg;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_LT  = 3'd4,
    OP_GT  = 3'd5,
    OP_EQ  = 3'd6,
    OP_NE  = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_ZERO_DEN = 2'd1,
    ERR_DIV_ZERO = 2'd2,
    ERR_RES_DEN  = 2'd3
  } err_t;

  localparam int unsigned FIELD_BITS = 32;

endpackage

// File: hw/rtl/rau_mul.sv
`timescale 1ns / 1ps
// Shift-add multiplier, one multiplier bit per cycle.
// Returns the product wrapped to W bits. No package dependencies.
module rau_mul #(
  parameter int unsigned W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] op_a,
  input  logic [W-1:0] op_b,
  output logic         done,
  output logic [W-1:0] prod
);

  localparam int unsigned CW = $clog2(W);

  logic         busy_r;
  logic         done_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0] acc_r;
  logic [W-1:0] mcand_r;
  logic [W-1:0] mplier_r;

  // Step counter and completion pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Accumulate one partial product a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r    <= '0;
      mcand_r  <= op_a;
      mplier_r <= op_b;
    end else if (busy_r) begin
      if (mplier_r[0]) begin
        acc_r <= acc_r + mcand_r;
      end
      mcand_r  <= {mcand_r[W-2:0], 1'b0};
      mplier_r <= {1'b0, mplier_r[W-1:1]};
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// File: hw/rtl/rau_div.sv
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// Gives quotient and remainder of W-bit operands. No package dependencies.
module rau_div #(
  parameter int unsigned W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quot,
  output logic [W-1:0] rem
);

  localparam int unsigned CW = $clog2(W);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [W:0]    rem_r;
  logic [W-1:0]  quo_r;
  logic [W-1:0]  dsr_r;
  logic [W:0]    trial;
  logic [W:0]    diff;
  logic          fits;

  // Trial subtract of the shifted remainder
  always_comb begin
    trial = {rem_r[W-1:0], quo_r[W-1]};
    diff  = trial - {1'b0, dsr_r};
    fits  = (trial >= {1'b0, dsr_r});
  end

  // Step counter and completion pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Shift dividend bits out and quotient bits in
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff : trial;
      quo_r <= {quo_r[W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r[W-1:0];

endmodule

// File: hw/rtl/rational_arithmetic_unit_top.sv
`timescale 1ns / 1ps
// Rational arithmetic unit: fraction add/sub/mul/div with GCD reduction, and compares.
// Results come from a sequence of multiplies and divides: three multiplies for add/sub and two
// for mul/div, then one divide per Euclid step and two divides to reduce the fraction; a
// compare takes two multiplies, and a zero denominator or divisor is flagged from the input beat.
// One item at a time: the next input beat is taken in the cycle after the result beat.
// Synchronous active-low reset clears the sequencer and the output beat. Uses rau_pkg/mul/div.
module rational_arithmetic_unit_top #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // a_num, a_den, b_num, b_den
  input  logic [2:0]   in_tuser,   // op
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [71:0]  out_tdata,  // res_num, res_den, cmp_true, zero fill
  output logic [1:0]   out_tuser   // error_code
);

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned FB = rau_pkg::FIELD_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_GCD, S_DDEN, S_DNUM, S_OUT
  } state_t;

  state_t          state_r;
  rau_pkg::op_t    op_r;
  logic [W-1:0]    ad_r, bn_r, bd_r;
  logic [W-1:0]    m0_r, m1_r;
  logic [W-1:0]    num_r, den_r, gcd_r, qden_r;
  logic [1:0]      midx_r;
  logic            mstart_r, dstart_r;
  logic [W-1:0]    ma_r, mb_r, da_r, db_r;
  logic            ovalid_r;
  logic [FB-1:0]   onum_r, oden_r;
  logic            ocmp_r;
  rau_pkg::err_t   oerr_r;

  logic            mdone, ddone;
  logic [W-1:0]    prod, quot, rem;
  logic [W-1:0]    in_an, in_ad, in_bn, in_bd;
  logic [W-1:0]    num_c, qsig;
  logic            is_add_sub, is_cmp;

  rau_mul #(.W(W)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mstart_r), .op_a(ma_r), .op_b(mb_r),
    .done(mdone), .prod(prod)
  );

  rau_div #(.W(W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart_r), .dividend(da_r), .divisor(db_r),
    .done(ddone), .quot(quot), .rem(rem)
  );

  // Take input fields to word width
  always_comb begin
    in_an = W'($signed(in_tdata[31:0]));
    in_ad = W'($signed(in_tdata[63:32]));
    in_bn = W'($signed(in_tdata[95:64]));
    in_bd = W'($signed(in_tdata[127:96]));
    is_add_sub = (op_r == rau_pkg::OP_ADD) || (op_r == rau_pkg::OP_SUB);
    is_cmp     = op_r[2];
    case (op_r)
      rau_pkg::OP_ADD: num_c = m0_r + m1_r;
      rau_pkg::OP_SUB: num_c = m0_r - m1_r;
      default:         num_c = m0_r;
    endcase
    // Restore the dividend sign on the quotient
    qsig = (state_r == S_DDEN) ? (den_r[W-1] ? -quot : quot)
                               : (num_r[W-1] ? -quot : quot);
  end

  // Sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      mstart_r <= 1'b0;
      dstart_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      mstart_r <= 1'b0;
      dstart_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            op_r   <= rau_pkg::op_t'(in_tuser);
            ad_r   <= in_ad;
            bn_r   <= in_bn;
            bd_r   <= in_bd;
            onum_r <= '0;
            oden_r <= '0;
            ocmp_r <= 1'b0;
            if (in_ad == '0 || in_bd == '0) begin
              oerr_r   <= rau_pkg::ERR_ZERO_DEN;
              ovalid_r <= 1'b1;
              state_r  <= S_OUT;
            end else if (rau_pkg::op_t'(in_tuser) == rau_pkg::OP_DIV && in_bn == '0) begin
              oerr_r   <= rau_pkg::ERR_DIV_ZERO;
              ovalid_r <= 1'b1;
              state_r  <= S_OUT;
            end else begin
              oerr_r   <= rau_pkg::ERR_NONE;
              midx_r   <= 2'd0;
              ma_r     <= in_an;
              mb_r     <= (rau_pkg::op_t'(in_tuser) == rau_pkg::OP_MUL) ? in_bn : in_bd;
              mstart_r <= 1'b1;
              state_r  <= S_MUL;
            end
          end
        end
        S_MUL: begin
          if (mdone) begin
            midx_r <= midx_r + 2'd1;
            if (midx_r == 2'd0) begin
              m0_r     <= prod;
              ma_r     <= ad_r;
              mb_r     <= (op_r == rau_pkg::OP_MUL) ? bd_r : bn_r;
              mstart_r <= 1'b1;
            end else if (midx_r == 2'd1 && is_add_sub) begin
              m1_r     <= prod;
              ma_r     <= ad_r;
              mb_r     <= bd_r;
              mstart_r <= 1'b1;
            end else if (midx_r == 2'd1 && is_cmp) begin
              case (op_r)
                rau_pkg::OP_LT: ocmp_r <= ($signed(m0_r) < $signed(prod));
                rau_pkg::OP_GT: ocmp_r <= ($signed(prod) < $signed(m0_r));
                rau_pkg::OP_EQ: ocmp_r <= (m0_r == prod);
                default:        ocmp_r <= (m0_r != prod);
              endcase
              ovalid_r <= 1'b1;
              state_r  <= S_OUT;
            end else if (prod == '0) begin
              oerr_r   <= rau_pkg::ERR_RES_DEN;
              ovalid_r <= 1'b1;
              state_r  <= S_OUT;
            end else begin
              num_r    <= num_c;
              den_r    <= prod;
              da_r     <= num_c[W-1] ? -num_c : num_c;
              db_r     <= prod[W-1] ? -prod : prod;
              dstart_r <= 1'b1;
              state_r  <= S_GCD;
            end
          end
        end
        S_GCD: begin
          // Euclid: divisor becomes dividend, remainder becomes divisor
          if (ddone) begin
            if (rem == '0) begin
              gcd_r    <= db_r;
              da_r     <= den_r[W-1] ? -den_r : den_r;
              dstart_r <= 1'b1;
              state_r  <= S_DDEN;
            end else begin
              da_r     <= db_r;
              db_r     <= rem;
              dstart_r <= 1'b1;
            end
          end
        end
        S_DDEN: begin
          if (ddone) begin
            qden_r   <= qsig;
            da_r     <= num_r[W-1] ? -num_r : num_r;
            db_r     <= gcd_r;
            dstart_r <= 1'b1;
            state_r  <= S_DNUM;
          end
        end
        S_DNUM: begin
          if (ddone) begin
            if (qden_r[W-1]) begin
              onum_r <= FB'($signed(-qsig));
              oden_r <= FB'($signed(-qden_r));
            end else begin
              onum_r <= FB'($signed(qsig));
              oden_r <= FB'($signed(qden_r));
            end
            ovalid_r <= 1'b1;
            state_r  <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_tready) begin
            ovalid_r <= 1'b0;
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = {7'd0, ocmp_r, oden_r, onum_r};
  assign out_tuser  = oerr_r;

endmodule
